[src/bfa_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types, codes and helpers for the best-fit free-list allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ADDR_W         = 32;
  localparam int DEF_MAX_BLOCKS = 256;
  localparam int CNT_OUT_W      = 9;
  localparam int ALIGN_W        = 5;
  localparam int ALIGN_CAP      = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;

  localparam logic [ADDR_W-1:0] HALF_RANGE = {1'b0, {(ADDR_W-1){1'b1}}};

  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE = 2'd3;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_FULL     = 2'd2,
    ST_FOREIGN  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RD_SCAN     = 2'd0,
    RD_FETCH    = 2'd1,
    RD_SHIFT_DN = 2'd2,
    RD_SHIFT_UP = 2'd3
  } rd_kind_t;

  typedef enum logic [2:0] {
    WR_NONE   = 3'd0,
    WR_RESET  = 3'd1,
    WR_ALLOC  = 3'd2,
    WR_HIT_A  = 3'd3,
    WR_HIT_B  = 3'd4,
    WR_MERGE  = 3'd5,
    WR_INSERT = 3'd6
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_INC  = 2'd2,
    CNT_DEC  = 2'd3
  } cnt_op_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] free_address;
    logic              is_own;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_W-1:0]    granted_address;
    logic [ADDR_W-1:0]    high_water;
    logic [CNT_OUT_W-1:0] block_count;
  } alloc_rsp_t;

  typedef struct packed {
    logic     load;
    logic     rd_en;
    rd_kind_t rd_kind;
    wr_op_t   wr_op;
    cnt_op_t  cnt_op;
    logic     set_status;
    status_t  status;
    logic     alloc_commit;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       own;
    logic       count_zero;
    logic       count_full;
    logic       alloc_ok;
    logic       alloc_drop;
    logic       hit_a;
    logic       hit_b;
    logic       has_next;
    logic       merge_next;
  } dp_sts_t;

  // round up to the capped power-of-two alignment, full precision
  function automatic logic [ADDR_W:0] round_up(input logic [ADDR_W-1:0] v,
                                               input logic [ALIGN_W-1:0] lg);
    logic [ALIGN_W-1:0] l;
    logic [ADDR_W:0]    m;
    l = (lg > ALIGN_W'(ALIGN_CAP)) ? ALIGN_W'(ALIGN_CAP) : lg;
    m = ((ADDR_W+1)'(1) << l) - (ADDR_W+1)'(1);
    return ({1'b0, v} + m) & ~m;
  endfunction

endpackage
`default_nettype wire

[src/bfa_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer: list scan, resolve, neighbour fetch and list shifting.
// ----------------------------------------------------------------------------
module bfa_ctrl import bfa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int IDX_W      = $clog2(MAX_BLOCKS),
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  output logic                  done,
  input  wire dp_sts_t          sts,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [IDX_W-1:0] sel_idx,
  input  wire logic [IDX_W-1:0] hit_idx,
  input  wire logic [CNT_W-1:0] pos,
  output dp_cmd_t               cmd,
  output logic [IDX_W-1:0]      rd_addr
);

  typedef enum logic [9:0] {
    S_IDLE       = 10'b0000000001,
    S_DECODE     = 10'b0000000010,
    S_SCAN       = 10'b0000000100,
    S_RESOLVE    = 10'b0000001000,
    S_FETCH      = 10'b0000010000,
    S_FETCH_WAIT = 10'b0000100000,
    S_SHIFT_DN   = 10'b0001000000,
    S_SHIFT_UP   = 10'b0010000000,
    S_INSERT     = 10'b0100000000,
    S_DONE       = 10'b1000000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] ptr, ptr_next;
  logic [CNT_W-1:0] ptr_dec;

  assign ptr_dec = ptr - CNT_W'(1);
  assign busy    = (state != S_IDLE);
  assign done    = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  always_comb begin
    cmd        = '0;
    rd_addr    = ptr[IDX_W-1:0];
    ptr_next   = ptr;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (sts.mode)
          MODE_RESET: begin
            cmd.wr_op  = WR_RESET;
            cmd.cnt_op = CNT_ONE;
          end
          MODE_ALLOC: begin
            if (sts.count_zero) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_NO_SPACE;
            end else begin
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
          MODE_FREE: begin
            if (!sts.own) begin
              cmd.set_status = 1'b1;
              cmd.status     = ST_FOREIGN;
            end else begin
              ptr_next   = '0;
              state_next = S_SCAN;
            end
          end
          default: ;
        endcase
      end
      S_SCAN: begin
        if (ptr < count) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_kind = RD_SCAN;
          ptr_next    = ptr + CNT_W'(1);
        end else begin
          state_next = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_next = S_DONE;
        if (sts.mode == MODE_ALLOC) begin
          if (sts.alloc_ok) begin
            cmd.alloc_commit = 1'b1;
            if (sts.alloc_drop) begin
              ptr_next   = CNT_W'(sel_idx) + CNT_W'(1);
              state_next = S_SHIFT_DN;
            end else begin
              cmd.wr_op = WR_ALLOC;
            end
          end else begin
            cmd.set_status = 1'b1;
            cmd.status     = ST_NO_SPACE;
          end
        end else if (sts.hit_a) begin
          if (sts.has_next) begin
            ptr_next   = CNT_W'(hit_idx) + CNT_W'(1);
            state_next = S_FETCH;
          end else begin
            cmd.wr_op = WR_HIT_A;
          end
        end else if (sts.hit_b) begin
          cmd.wr_op = WR_HIT_B;
        end else if (sts.count_full) begin
          cmd.set_status = 1'b1;
          cmd.status     = ST_FULL;
        end else begin
          ptr_next   = count;
          state_next = S_SHIFT_UP;
        end
      end
      S_FETCH: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_kind = RD_FETCH;
        state_next  = S_FETCH_WAIT;
      end
      S_FETCH_WAIT: begin
        if (sts.merge_next) begin
          cmd.wr_op  = WR_MERGE;
          ptr_next   = ptr + CNT_W'(1);
          state_next = S_SHIFT_DN;
        end else begin
          cmd.wr_op  = WR_HIT_A;
          state_next = S_DONE;
        end
      end
      S_SHIFT_DN: begin
        if (ptr < count) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_kind = RD_SHIFT_DN;
          ptr_next    = ptr + CNT_W'(1);
        end else begin
          cmd.cnt_op = CNT_DEC;
          state_next = S_DONE;
        end
      end
      S_SHIFT_UP: begin
        if (ptr > pos) begin
          rd_addr     = ptr_dec[IDX_W-1:0];
          cmd.rd_en   = 1'b1;
          cmd.rd_kind = RD_SHIFT_UP;
          ptr_next    = ptr_dec;
        end else begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        cmd.wr_op  = WR_INSERT;
        cmd.cnt_op = CNT_INC;
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for more than one cycle");
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not make the block busy");
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a request in progress");

endmodule
`default_nettype wire

[src/bfa_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bfa_dpath
// Free-list memory, configuration registers, scan trackers and result.
// ----------------------------------------------------------------------------
module bfa_dpath import bfa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
  parameter int IDX_W      = $clog2(MAX_BLOCKS),
  parameter int CNT_W      = $clog2(MAX_BLOCKS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire alloc_req_t            req,
  output alloc_rsp_t                 result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire dp_cmd_t               cmd,
  input  wire logic [IDX_W-1:0]      rd_addr,
  output dp_sts_t                    sts,
  output logic [CNT_W-1:0]           count,
  output logic [IDX_W-1:0]           sel_idx,
  output logic [IDX_W-1:0]           hit_idx,
  output logic [CNT_W-1:0]           pos
);

  logic [ADDR_W-1:0]  mem_start [MAX_BLOCKS];
  logic [ADDR_W-1:0]  mem_len   [MAX_BLOCKS];

  logic [ADDR_W-1:0]  base, size;
  logic [ALIGN_W-1:0] align;
  logic               measure;
  logic [ADDR_W-1:0]  peak;

  logic [1:0]         mode;
  logic               own;
  logic [ADDR_W:0]    sz;
  logic [ADDR_W-1:0]  ptr_addr;
  status_t            status_q;
  logic [ADDR_W-1:0]  granted;

  logic               best_found;
  logic [IDX_W-1:0]   best_idx, last_idx;
  logic [ADDR_W-1:0]  best_start, best_len, last_start, last_len;
  logic               hit_a, hit_b, pos_found;
  logic [ADDR_W-1:0]  hit_start, hit_len;
  logic [CNT_W-1:0]   pos_q;

  logic               rd_valid;
  logic [IDX_W-1:0]   rd_idx;
  rd_kind_t           rd_kind;
  logic [ADDR_W-1:0]  rd_start, rd_len;

  logic [ADDR_W-1:0]  sz32, sel_start, sel_len, peak_end, reset_len, hit_sum;
  logic [ADDR_W:0]    base_round, pad;
  logic               is_last;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]  wr_start, wr_len;

  assign sz32       = sz[ADDR_W-1:0];
  assign sel_idx    = best_found ? best_idx : last_idx;
  assign sel_start  = best_found ? best_start : last_start;
  assign sel_len    = best_found ? best_len : last_len;
  assign peak_end   = sel_start - base + sz32;
  assign hit_sum    = hit_len + sz32;
  assign base_round = round_up(base, align);
  assign pad        = base_round - {1'b0, base};
  assign reset_len  = measure ? HALF_RANGE :
                      (({1'b0, size} >= pad) ? (size - pad[ADDR_W-1:0]) : '0);
  assign is_last    = ((CNT_W'(rd_idx) + CNT_W'(1)) == count);
  assign hit_idx    = best_idx;
  assign pos        = pos_found ? pos_q : count;

  assign sts.mode       = mode;
  assign sts.own        = own;
  assign sts.count_zero = (count == '0);
  assign sts.count_full = (count >= CNT_W'(MAX_BLOCKS));
  assign sts.alloc_ok   = best_found || ({1'b0, last_len} >= sz);
  assign sts.alloc_drop = ({1'b0, sel_len} == sz);
  assign sts.hit_a      = hit_a;
  assign sts.hit_b      = hit_b;
  assign sts.has_next   = ((CNT_W'(best_idx) + CNT_W'(1)) < count);
  assign sts.merge_next = ((hit_start + hit_sum) == rd_start);

  assign result.status          = status_q;
  assign result.granted_address = granted;
  assign result.high_water      = peak;
  assign result.block_count     = CNT_OUT_W'(count);

  // write port: sequencer updates first, else trailing shift beats
  always_comb begin
    wr_en    = 1'b1;
    wr_addr  = best_idx;
    wr_start = hit_start;
    wr_len   = hit_sum;
    case (cmd.wr_op)
      WR_RESET: begin
        wr_addr  = '0;
        wr_start = base_round[ADDR_W-1:0];
        wr_len   = reset_len;
      end
      WR_ALLOC: begin
        wr_addr  = sel_idx;
        wr_start = sel_start + sz32;
        wr_len   = sel_len - sz32;
      end
      WR_HIT_A: ;
      WR_HIT_B: wr_start = ptr_addr;
      WR_MERGE: wr_len = hit_sum + rd_len;
      WR_INSERT: begin
        wr_addr  = pos[IDX_W-1:0];
        wr_start = ptr_addr;
        wr_len   = sz32;
      end
      default: begin
        wr_start = rd_start;
        wr_len   = rd_len;
        wr_en    = rd_valid && (rd_kind == RD_SHIFT_DN || rd_kind == RD_SHIFT_UP);
        wr_addr  = (rd_kind == RD_SHIFT_DN) ? (rd_idx - IDX_W'(1)) : (rd_idx + IDX_W'(1));
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[wr_addr] <= wr_start;
      mem_len[wr_addr]   <= wr_len;
    end
    if (cmd.rd_en) begin
      rd_start <= mem_start[rd_addr];
      rd_len   <= mem_len[rd_addr];
      rd_idx   <= rd_addr;
      rd_kind  <= cmd.rd_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base     <= '0;
      size     <= '0;
      align    <= '0;
      measure  <= 1'b0;
      count    <= '0;
      peak     <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_BASE:    base    <= cfg_data;
          REG_SIZE:    size    <= cfg_data;
          REG_ALIGN:   align   <= cfg_data[ALIGN_W-1:0];
          REG_MEASURE: measure <= cfg_data[0];
          default: ;
        endcase
      end
      case (cmd.cnt_op)
        CNT_ONE: count <= CNT_W'(1);
        CNT_INC: count <= count + CNT_W'(1);
        CNT_DEC: count <= count - CNT_W'(1);
        default: ;
      endcase
      if (cmd.alloc_commit && peak_end > peak) begin
        peak <= peak_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode       <= req.mode;
      own        <= req.is_own;
      sz         <= round_up(req.request_size, align);
      ptr_addr   <= req.free_address;
      status_q   <= ST_OK;
      granted    <= '0;
      best_found <= 1'b0;
      hit_a      <= 1'b0;
      hit_b      <= 1'b0;
      pos_found  <= 1'b0;
    end else begin
      if (cmd.set_status) begin
        status_q <= cmd.status;
      end
      if (cmd.alloc_commit) begin
        granted <= sel_start;
      end
      if (rd_valid && rd_kind == RD_SCAN) begin
        if (mode == MODE_ALLOC) begin
          if (is_last) begin
            last_idx   <= rd_idx;
            last_start <= rd_start;
            last_len   <= rd_len;
          end else if ({1'b0, rd_len} >= sz && (!best_found || rd_len <= best_len)) begin
            best_found <= 1'b1;
            best_idx   <= rd_idx;
            best_start <= rd_start;
            best_len   <= rd_len;
          end
        end else begin
          if (!hit_a && !hit_b) begin
            if ((rd_start + rd_len) == ptr_addr) begin
              hit_a     <= 1'b1;
              best_idx  <= rd_idx;
              hit_start <= rd_start;
              hit_len   <= rd_len;
            end else if ((ptr_addr + sz32) == rd_start) begin
              hit_b     <= 1'b1;
              best_idx  <= rd_idx;
              hit_start <= rd_start;
              hit_len   <= rd_len;
            end
          end
          if (!pos_found && rd_start >= ptr_addr) begin
            pos_found <= 1'b1;
            pos_q     <= CNT_W'(rd_idx);
          end
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_BLOCKS))
    else $error("free block count beyond table depth");
  a_inc_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.cnt_op == CNT_INC) |-> (count < CNT_W'(MAX_BLOCKS)))
    else $error("insert into a full table");

endmodule
`default_nettype wire

[src/best_fit_free_list_allocator_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_top
// Best-fit free-list allocator with coalescing over one managed buffer.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its single result
// appears on result for exactly one cycle with done high and cannot be held
// off, so the receiver must take it then. A request walks the free list one
// entry per cycle through a memory with one read and one write port: list
// reset and foreign or unused requests finish straight after decode, while
// allocate and free scan all N free blocks and then shift the list when an
// entry is removed or inserted.
// Configuration writes are taken at any edge with cfg_we high.
module best_fit_free_list_allocator_top import bfa_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire alloc_req_t            req,
  output logic                       done,
  output alloc_rsp_t                 result,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  dp_cmd_t          cmd;
  dp_sts_t          sts;
  logic [IDX_W-1:0] rd_addr, sel_idx, hit_idx;
  logic [CNT_W-1:0] count, pos;

  bfa_ctrl #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .sts    (sts),
    .count  (count),
    .sel_idx(sel_idx),
    .hit_idx(hit_idx),
    .pos    (pos),
    .cmd    (cmd),
    .rd_addr(rd_addr)
  );

  bfa_dpath #(
    .MAX_BLOCKS(MAX_BLOCKS),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .rd_addr  (rd_addr),
    .sts      (sts),
    .count    (count),
    .sel_idx  (sel_idx),
    .hit_idx  (hit_idx),
    .pos      (pos)
  );

endmodule
`default_nettype wire

[verif/best_fit_free_list_allocator_top_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator_top_test
// Self-checking test of the best-fit free-list allocator. A behavioural copy
// of the free table predicts every result beat; directed tests cover list
// reset, empty table, oversized, zero-size and foreign requests, merging and
// a full table, then random alloc/free traffic runs under three register
// settings with varying request gaps.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator_top_test import bfa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK  = 256;
  localparam int LIMIT = 4000;
  localparam longint unsigned AMASK = 64'hFFFF_FFFF;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  alloc_req_t            req;
  logic                  done;
  alloc_rsp_t            result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  best_fit_free_list_allocator_top #(.MAX_BLOCKS(NBLK)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // free table copy
  longint unsigned tbl_start[NBLK];
  longint unsigned tbl_len[NBLK];
  int unsigned     tbl_count;
  longint unsigned peak;
  longint unsigned m_base, m_size, m_align, m_measure;

  alloc_rsp_t      rsp_q[$];
  longint unsigned live_addr[$];
  longint unsigned live_size[$];
  int              errors;
  int              idle_cycles;
  int              gap_pct;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned align_pad(longint unsigned v);
    longint unsigned a;
    a = 64'd1 << ((m_align > 16) ? 16 : m_align);
    return (a - (v % a)) % a;
  endfunction

  function automatic void remove_block(int unsigned idx);
    if (tbl_count == 0) return;
    tbl_count--;
    for (int unsigned j = idx; j < tbl_count; j++) begin
      tbl_start[j] = tbl_start[j+1];
      tbl_len[j]   = tbl_len[j+1];
    end
  endfunction

  function automatic status_t take_region(longint unsigned rq, output longint unsigned grant);
    longint unsigned sz, best_len, a, e;
    int best;
    sz = rq + align_pad(rq);
    best_len = '1;
    best = -1;
    grant = 0;
    if (tbl_count == 0) return ST_NO_SPACE;
    for (int unsigned i = 0; i + 1 < tbl_count; i++) begin
      if (tbl_len[i] >= sz && tbl_len[i] <= best_len) begin
        best = i;
        best_len = tbl_len[i];
      end
    end
    if (best < 0) begin
      if (tbl_len[tbl_count-1] >= sz) best = tbl_count - 1;
      else return ST_NO_SPACE;
    end
    a = tbl_start[best];
    tbl_start[best] = (a + sz) & AMASK;
    tbl_len[best] -= sz;
    if (tbl_len[best] == 0) remove_block(best);
    e = (a - m_base + sz) & AMASK;
    if (e > peak) peak = e;
    grant = a;
    return ST_OK;
  endfunction

  function automatic status_t return_region(longint unsigned rq, longint unsigned p);
    longint unsigned sz;
    int unsigned pos;
    sz = (rq + align_pad(rq)) & AMASK;
    for (int unsigned i = 0; i < tbl_count; i++) begin
      if (((tbl_start[i] + tbl_len[i]) & AMASK) == p) begin
        tbl_len[i] = (tbl_len[i] + sz) & AMASK;
        if (i + 1 < tbl_count && ((tbl_start[i] + tbl_len[i]) & AMASK) == tbl_start[i+1]) begin
          tbl_len[i] = (tbl_len[i] + tbl_len[i+1]) & AMASK;
          remove_block(i + 1);
        end
        return ST_OK;
      end
      if (((p + sz) & AMASK) == tbl_start[i]) begin
        tbl_start[i] = p;
        tbl_len[i] = (tbl_len[i] + sz) & AMASK;
        if (i > 0 && ((tbl_start[i-1] + tbl_len[i-1]) & AMASK) == tbl_start[i]) begin
          tbl_len[i-1] = (tbl_len[i-1] + tbl_len[i]) & AMASK;
          remove_block(i);
        end
        return ST_OK;
      end
    end
    if (tbl_count >= NBLK) return ST_FULL;
    pos = 0;
    while (pos < tbl_count && tbl_start[pos] < p) pos++;
    for (int unsigned i = tbl_count; i > pos; i--) begin
      tbl_start[i] = tbl_start[i-1];
      tbl_len[i]   = tbl_len[i-1];
    end
    tbl_start[pos] = p;
    tbl_len[pos]   = sz;
    tbl_count++;
    return ST_OK;
  endfunction

  function automatic alloc_rsp_t predict_rsp(alloc_req_t r);
    alloc_rsp_t      o;
    longint unsigned g, pd;
    status_t         st;
    g = 0;
    st = ST_OK;
    case (r.mode)
      MODE_RESET: begin
        pd = align_pad(m_base);
        tbl_count = 1;
        tbl_start[0] = (m_base + pd) & AMASK;
        if (m_measure != 0) tbl_len[0] = {32'd0, HALF_RANGE};
        else tbl_len[0] = (m_size >= pd) ? m_size - pd : 0;
      end
      MODE_ALLOC: st = take_region(64'(r.request_size), g);
      MODE_FREE:  st = r.is_own ?
                       return_region(64'(r.request_size), 64'(r.free_address)) : ST_FOREIGN;
      default: ;
    endcase
    o.status          = st;
    o.granted_address = g[31:0];
    o.high_water      = peak[31:0];
    o.block_count     = tbl_count[CNT_OUT_W-1:0];
    return o;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_BASE:    m_base = 64'(val);
      REG_SIZE:    m_size = 64'(val);
      REG_ALIGN:   m_align = 64'(val[ALIGN_W-1:0]);
      REG_MEASURE: m_measure = 64'(val[0]);
      default: ;
    endcase
  endtask

  task automatic set_regs(logic [31:0] b, logic [31:0] s, logic [31:0] al, logic [31:0] me);
    write_reg(REG_BASE, b);
    write_reg(REG_SIZE, s);
    write_reg(REG_ALIGN, al);
    write_reg(REG_MEASURE, me);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_beat(logic [1:0] md, logic [31:0] sz, logic [31:0] ad, logic own);
    alloc_req_t r;
    alloc_rsp_t e;
    int gap;
    r.mode = md;
    r.request_size = sz;
    r.free_address = ad;
    r.is_own = own;
    gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    do @(posedge clk); while (busy);
    e = predict_rsp(r);
    rsp_q.push_back(e);
    if (md == MODE_ALLOC && e.status == ST_OK) begin
      live_addr.push_back(64'(e.granted_address));
      live_size.push_back(64'(sz));
    end
    if (md == MODE_RESET) begin
      live_addr.delete();
      live_size.delete();
    end
  endtask

  task automatic drain;
    start <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    alloc_rsp_t e;
    if (!rst && done) begin
      if (rsp_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", result);
      end else begin
        e = rsp_q.pop_front();
        if (result.status !== e.status || result.granted_address !== e.granted_address ||
            result.high_water !== e.high_water || result.block_count !== e.block_count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp st=%0d addr=%h hw=%h cnt=%0d, got %0d %h %h %0d",
                     e.status, e.granted_address, e.high_water, e.block_count,
                     result.status, result.granted_address, result.high_water,
                     result.block_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  task automatic test_directed;
    send_beat(MODE_ALLOC, 32'd8, 32'd0, 1'b1);
    send_beat(MODE_FREE, 32'd4, 32'h40, 1'b0);
    send_beat(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    drain();
    set_regs(32'h0000_1003, 32'd4096, 32'd4, 32'd0);
    send_beat(MODE_RESET, 32'd0, 32'd0, 1'b0);
    send_beat(MODE_ALLOC, 32'd0, 32'd0, 1'b0);
    send_beat(MODE_ALLOC, 32'd1, 32'd0, 1'b0);
    send_beat(MODE_ALLOC, 32'hFFFF_FFFF, 32'd0, 1'b0);
    send_beat(MODE_ALLOC, 32'hFFFF_FFF1, 32'd0, 1'b0);
    send_beat(MODE_ALLOC, 32'd100, 32'd0, 1'b0);
    send_beat(MODE_FREE, 32'd16, 32'h0000_1010, 1'b1);
    send_beat(MODE_FREE, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
    send_beat(MODE_FREE, 32'd16, 32'h0000_1010, 1'b0);
    send_beat(MODE_ALLOC, 32'd4000, 32'd0, 1'b1);
    send_beat(MODE_ALLOC, 32'd64, 32'd0, 1'b1);
    drain();
    // buffer shorter than the alignment padding
    set_regs(32'h0000_0001, 32'd3, 32'd31, 32'd0);
    send_beat(MODE_RESET, 32'd0, 32'd0, 1'b1);
    send_beat(MODE_ALLOC, 32'd0, 32'd0, 1'b1);
    send_beat(MODE_ALLOC, 32'd0, 32'd0, 1'b1);
    drain();
  endtask

  task automatic test_full_table;
    set_regs(32'd0, 32'd16, 32'd0, 32'd0);
    send_beat(MODE_RESET, 32'd0, 32'd0, 1'b1);
    for (int i = 0; i < NBLK + 1; i++)
      send_beat(MODE_FREE, 32'd1, 32'h100 + 2 * i, 1'b1);
    send_beat(MODE_FREE, 32'd1, 32'h101, 1'b1);
    send_beat(MODE_FREE, 32'd1, 32'h1000, 1'b1);
    send_beat(MODE_ALLOC, 32'd1, 32'd0, 1'b1);
    send_beat(MODE_ALLOC, 32'd3, 32'd0, 1'b1);
    drain();
  endtask

  task automatic test_random(int n);
    int k, pick;
    logic [31:0] sz;
    send_beat(MODE_RESET, $urandom, $urandom, 1'b1);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      sz = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 300);
      if (pick < 45) begin
        send_beat(MODE_ALLOC, sz, $urandom, 1'($urandom_range(1)));
      end else if (pick < 82 && live_addr.size() != 0) begin
        k = $urandom_range(live_addr.size() - 1);
        send_beat(MODE_FREE, 32'(live_size[k]), 32'(live_addr[k]), 1'b1);
        live_addr.delete(k);
        live_size.delete(k);
      end else if (pick < 88) begin
        send_beat(MODE_FREE, sz, $urandom, 1'b0);
      end else if (pick < 93) begin
        send_beat(MODE_FREE, sz, $urandom, 1'b1);
      end else if (pick < 97) begin
        send_beat(MODE_RESET, $urandom, $urandom, 1'($urandom_range(1)));
      end else begin
        send_beat(2'd3, $urandom, $urandom, 1'($urandom_range(1)));
      end
    end
    drain();
  endtask

  initial begin
    errors = 0;
    gap_pct = 24;
    tbl_count = 0;
    peak = 0;
    m_base = 0;
    m_size = 0;
    m_align = 0;
    m_measure = 0;
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    set_regs($urandom, 32'd4096, 32'd3, 32'd0);
    test_random(40);
    gap_pct = 49;
    set_regs(32'hFFFF_F000, 32'hFFFF_FFFF, 32'd17, 32'd0);
    test_random(40);
    gap_pct = 0;
    set_regs(32'd0, 32'd0, 32'd16, 32'd1);
    test_random(40);
    repeat (20) @(posedge clk);
    if (errors == 0 && rsp_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
